// ----- rtl/jvkf_pkg.sv -----
// ----------------------------------------------------------------------------
// jvkf_pkg: shared constants for the joint velocity Kalman filter
// Field widths, register indexes, reset values and sequencer sizes.
// ----------------------------------------------------------------------------
package jvkf_pkg;

    localparam int JVKF_NUM_JOINTS = 8;

    localparam int JOINT_W = 3;
    localparam int VEL_W   = 32;
    localparam int COV_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COVARIANCE = 2'd2;

    localparam logic [CFG_W-1:0] PN_RESET = 32'd17180;
    localparam logic [CFG_W-1:0] MN_RESET = 32'd429497;
    localparam logic [CFG_W-1:0] IC_RESET = 32'd429497;

    // one integer quotient bit plus sixteen fraction bits
    localparam int DIV_STEPS = GAIN_W + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

endpackage

// ----- rtl/joint_velocity_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// joint_velocity_kalman_filter: per-joint scalar Kalman filter
// Keeps an estimate and an error covariance per joint, forms the gain
// P/(P+R) with a restoring divider and updates both with one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_stall   | joint, measured_velocity
//  out      | output    | o_out_valid / i_out_stall | joint_out, filtered_velocity, gain
//  cfg      | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
//  An item passes through load, 17 divider steps, gain, two multiplies,
//  update and result, in that order, from accept onward.
//  An out-of-range joint goes straight to the result step and leaves the state alone.
//  Reset clears all estimates and loads every covariance with IC_RESET.
//  A stalled result holds in the output register; the next word is taken
//  meanwhile and its result waits in the final step until the register frees.
// ----------------------------------------------------------------------------
module joint_velocity_kalman_filter
    import jvkf_pkg::*;
#(
    parameter int NUM_JOINTS = JVKF_NUM_JOINTS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [JOINT_W-1:0]       i_joint,
    input  logic signed [VEL_W-1:0]  i_measured_velocity,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [JOINT_W-1:0]       o_joint_out,
    output logic signed [VEL_W-1:0]  o_filtered_velocity,
    output logic [GAIN_W-1:0]        o_gain,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    localparam int IDX_W   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int RANGE_W = $clog2(NUM_JOINTS + 1) + JOINT_W;
    localparam int SUM_W   = COV_W + 1;
    localparam int REM_W   = COV_W + 2;
    localparam int DIFF_W  = VEL_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int XS_W    = VEL_W + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_GAIN = 3'd3;
    localparam logic [2:0] S_MUL1 = 3'd4;
    localparam logic [2:0] S_MUL2 = 3'd5;
    localparam logic [2:0] S_COV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]               r_state, n_state;
    logic [CFG_W-1:0]         r_process_noise, r_measurement_noise;
    logic signed [VEL_W-1:0]  r_estimate [NUM_JOINTS];
    logic [COV_W-1:0]         r_covariance [NUM_JOINTS];

    logic [JOINT_W-1:0]       r_joint;
    logic signed [VEL_W-1:0]  r_z;
    logic signed [VEL_W-1:0]  r_x;
    logic [COV_W-1:0]         r_p;
    logic [SUM_W-1:0]         r_sum;
    logic [REM_W-1:0]         r_rem;
    logic [DIV_STEPS-1:0]     r_q;
    logic [CNT_W-1:0]         r_cnt;
    logic [GAIN_W-1:0]        r_k;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VEL_W-1:0]  r_xnew;

    logic                     r_out_valid;
    logic [JOINT_W-1:0]       r_out_joint;
    logic signed [VEL_W-1:0]  r_out_vel;
    logic [GAIN_W-1:0]        r_out_gain;

    logic [IDX_W-1:0]         idx;
    logic                     in_range;
    logic                     in_accept;
    logic                     out_free;
    logic                     div_ge;
    logic [REM_W-1:0]         div_rem;
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [GAIN_W:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [XS_W-1:0]   x_sum;
    logic signed [VEL_W-1:0]  x_sat;
    logic [SUM_W-1:0]         p_new;
    logic [COV_W-1:0]         p_sat;
    logic [GAIN_W-1:0]        k_sat;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign idx       = IDX_W'(r_joint);
    assign in_range  = RANGE_W'(i_joint) < RANGE_W'(NUM_JOINTS);

    // restoring divider step: compare and subtract, then shift
    assign div_ge  = r_rem >= REM_W'(r_sum);
    assign div_rem = div_ge ? (r_rem - REM_W'(r_sum)) : r_rem;

    // gain saturates when the quotient reaches one; zero divisor gives zero
    always_comb begin
        if (r_sum == '0) begin
            k_sat = '0;
        end else if (r_q[DIV_STEPS-1]) begin
            k_sat = GAIN_MAX;
        end else begin
            k_sat = r_q[GAIN_W-1:0];
        end
    end

    // shared multiplier: (z - x) * K first, then P * K
    assign mul_a = (r_state == S_MUL1) ? r_diff : $signed({1'b0, r_p});
    assign mul_b = $signed({1'b0, r_k});
    assign mul_p = PROD_W'(mul_a * mul_b);

    // arithmetic shift floors toward minus infinity
    assign x_sum = XS_W'(r_x) + XS_W'(r_prod >>> GAIN_W);
    always_comb begin
        if (x_sum > XS_W'(32'sh7FFF_FFFF)) begin
            x_sat = 32'sh7FFF_FFFF;
        end else if (x_sum < -XS_W'(64'sh8000_0000)) begin
            x_sat = -32'sh8000_0000;
        end else begin
            x_sat = x_sum[VEL_W-1:0];
        end
    end

    assign p_new = SUM_W'(r_p) - SUM_W'(r_prod[GAIN_W +: COV_W]) + SUM_W'(r_process_noise);
    assign p_sat = p_new[COV_W] ? {COV_W{1'b1}} : p_new[COV_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = in_range ? S_LOAD : S_DONE;
                end
            end
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_COV;
            S_COV:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state              <= S_IDLE;
            r_out_valid          <= 1'b0;
            r_process_noise      <= PN_RESET;
            r_measurement_noise  <= MN_RESET;
            for (int i = 0; i < NUM_JOINTS; i++) begin
                r_estimate[i]   <= '0;
                r_covariance[i] <= IC_RESET;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PROCESS_NOISE:      r_process_noise      <= i_cfg_data;
                    CFG_MEASUREMENT_NOISE:  r_measurement_noise  <= i_cfg_data;
                    // covariance reloads only at reset, which restores IC_RESET
                    CFG_INITIAL_COVARIANCE: ;
                    default: ;
                endcase
            end

            if (r_state == S_COV) begin
                r_estimate[idx]   <= r_xnew;
                r_covariance[idx] <= p_sat;
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_joint <= i_joint;
            r_z     <= i_measured_velocity;
            r_k     <= '0;
            r_xnew  <= '0;
        end
        unique case (r_state)
            S_LOAD: begin
                r_p   <= r_covariance[idx];
                r_x   <= r_estimate[idx];
                r_sum <= SUM_W'(r_covariance[idx]) + SUM_W'(r_measurement_noise);
                r_rem <= REM_W'(r_covariance[idx]);
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem  <= {div_rem[REM_W-2:0], 1'b0};
                r_q    <= {r_q[DIV_STEPS-2:0], div_ge};
                r_cnt  <= r_cnt + CNT_W'(1);
                r_diff <= DIFF_W'(r_z) - DIFF_W'(r_x);
            end
            S_GAIN: r_k    <= k_sat;
            S_MUL1: r_prod <= mul_p;
            S_MUL2: begin
                r_prod <= mul_p;
                r_xnew <= x_sat;
            end
            default: ;
        endcase
        if (r_state == S_DONE && out_free) begin
            r_out_joint <= r_joint;
            r_out_vel   <= r_xnew;
            r_out_gain  <= r_k;
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_joint_out         = r_out_joint;
    assign o_filtered_velocity = r_out_vel;
    assign o_gain              = r_out_gain;

endmodule

// ----- rtl/jvkf_checker.sv -----
// ----------------------------------------------------------------------------
// jvkf_checker: port-level checks for the joint velocity Kalman filter
// Watches handshakes and reset behavior on the top-level ports.
// ----------------------------------------------------------------------------
module jvkf_checker
    import jvkf_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic [JOINT_W-1:0]       i_joint,
    input logic signed [VEL_W-1:0]  i_measured_velocity,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [JOINT_W-1:0]       o_joint_out,
    input logic signed [VEL_W-1:0]  o_filtered_velocity,
    input logic [GAIN_W-1:0]        o_gain
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_joint_out)
            && $stable(o_filtered_velocity) && $stable(o_gain))
        else $error("result word changed while stalled");

    // a stalled input word holds on the ports
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_joint)
            && $stable(i_measured_velocity))
        else $error("input word changed while stalled");

    // an accepted word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after accept");

    // a new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // reset empties the output and frees the input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear handshake state");

endmodule

bind joint_velocity_kalman_filter jvkf_checker u_jvkf_checker (.*);
